>>> hw/rtl/rklc_pkg.sv
`timescale 1ns / 1ps

package rklc_pkg;

  // Operation codes carried in the op field.
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_COLOUR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS  = 2'd1;

  localparam logic [3:0] BASE_COLOUR_RESET = 4'd0;
  localparam logic [7:0] BRIGHTNESS_RESET  = 8'd255;
  localparam logic [3:0] PRESET_COUNT      = 4'd10;

  localparam logic [7:0]  NO_LED      = 8'd255;
  localparam logic [31:0] FADE_MS     = 32'd500;
  localparam logic [8:0]  RING_HALF_W = 9'd14;

  // Reciprocal constants: x / 100 for x < 2^15, x / 25 for x < 4096,
  // x / 14 for x < 4096.
  localparam logic [15:0] RECIP_100 = 16'd41944;
  localparam int unsigned SHIFT_100 = 22;
  localparam logic [11:0] RECIP_25  = 12'd2622;
  localparam int unsigned SHIFT_25  = 16;
  localparam logic [12:0] RECIP_14  = 13'd4682;
  localparam int unsigned SHIFT_14  = 16;

  typedef struct packed {
    logic        op;
    logic [7:0]  led_index;
    logic [7:0]  led_x;
    logic [7:0]  led_y;
    logic        wave_key;
    logic [31:0] now_ms;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_word_t;

  // One stored key press event.
  typedef struct packed {
    logic [7:0]  led;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        special;
    logic [31:0] stamp;
  } slot_t;

  typedef struct packed {
    logic record;
    logic load_query;
    logic init_colour;
    logic issue;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_last;
    logic pipe_empty;
  } dp_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_WALK,
    ST_DRAIN,
    ST_RESULT
  } ctrl_state_e;

  function automatic out_word_t preset_colour(input logic [3:0] idx);
    out_word_t c;
    unique case (idx)
      4'd0:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
      4'd1:    c = '{red: 8'd255, green: 8'd200, blue: 8'd0};
      4'd2:    c = '{red: 8'd148, green: 8'd0,   blue: 8'd211};
      4'd3:    c = '{red: 8'd255, green: 8'd20,  blue: 8'd147};
      4'd4:    c = '{red: 8'd0,   green: 8'd200, blue: 8'd200};
      4'd5:    c = '{red: 8'd255, green: 8'd80,  blue: 8'd0};
      4'd6:    c = '{red: 8'd50,  green: 8'd255, blue: 8'd50};
      4'd7:    c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
      4'd8:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
      default: c = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
    endcase
    return c;
  endfunction

  // Exact x / 255 for any 16-bit product of two bytes.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] s;
    s = x + 16'd1 + {8'd0, x[15:8]};
    return s[15:8];
  endfunction

endpackage

>>> hw/rtl/rklc_ram.sv
`timescale 1ns / 1ps

module rklc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/rklc_ctrl.sv
`timescale 1ns / 1ps

module rklc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic                 op_i,
  input  rklc_pkg::dp_status_t status_i,
  output rklc_pkg::dp_cmd_t    cmd_o,
  output logic                 busy,
  output logic                 result_strobe_o
);

  import rklc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    busy            = 1'b1;
    result_strobe_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (op_i == OP_QUERY) begin
            cmd_o.load_query = 1'b1;
            state_d          = ST_BASE;
          end else begin
            cmd_o.record = 1'b1;
          end
        end
      end
      ST_BASE: begin
        cmd_o.init_colour = 1'b1;
        state_d           = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.issue = 1'b1;
        if (status_i.walk_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status_i.pipe_empty) begin
          state_d = ST_RESULT;
        end
      end
      ST_RESULT: begin
        result_strobe_o = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/rklc_datapath.sv
`timescale 1ns / 1ps

module rklc_datapath #(
  parameter int unsigned EVENT_SLOTS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rklc_pkg::in_word_t                  in_i,
  input  rklc_pkg::dp_cmd_t                   cmd_i,
  output rklc_pkg::dp_status_t                status_o,
  input  logic                                cfg_valid_i,
  input  logic [rklc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [7:0]                          cfg_data_i,
  output rklc_pkg::out_word_t                 colour_o
);

  import rklc_pkg::*;

  localparam int unsigned SlotW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(EVENT_SLOTS - 1);

  // Configuration registers.
  logic [3:0] base_idx_q;
  logic [7:0] bright_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_idx_q <= BASE_COLOUR_RESET;
      bright_q   <= BRIGHTNESS_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_BASE_COLOUR) begin
        base_idx_q <= cfg_data_i[3:0];
      end else if (cfg_index_i == CFG_BRIGHTNESS) begin
        bright_q <= cfg_data_i;
      end
    end
  end

  // Ring write pointer, walk counter and active flags.
  logic [SlotW-1:0]       next_slot_q, next_slot_d;
  logic [SlotW-1:0]       walk_q, walk_d;
  logic [EVENT_SLOTS-1:0] active_q, active_d;
  logic                   rec_we;
  slot_t                  rec_word;
  slot_t                  rd_word;

  assign rec_we   = cmd_i.record && (in_i.led_index != NO_LED);
  assign rec_word = '{led: in_i.led_index, x: in_i.led_x, y: in_i.led_y,
                      special: in_i.wave_key, stamp: in_i.now_ms};

  rklc_ram #(
    .Width ($bits(slot_t)),
    .Depth (EVENT_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (next_slot_q),
    .wdata_i (rec_word),
    .raddr_i (walk_q),
    .rdata_o (rd_word)
  );

  // Latched query.
  logic [7:0]  q_led_q, q_x_q, q_y_q;
  logic [31:0] q_now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_query) begin
      q_led_q <= in_i.led_index;
      q_x_q   <= in_i.led_x;
      q_y_q   <= in_i.led_y;
      q_now_q <= in_i.now_ms;
    end
  end

  // Pipeline valid flags: stage 1 sees the memory read data.
  logic             v1_q, v2_q, v3_q, v4_q;
  logic [SlotW-1:0] idx1_q;

  // Stage 1: elapsed time, expiry, distance.
  logic [31:0] el;
  logic        s1_active, s1_live, s1_expired;
  logic [8:0]  el9;
  logic [7:0]  dx, dy;
  logic        s2_live_q, s2_special_q, s2_match_q;
  logic [14:0] s2_el51_q;
  logic [10:0] s2_el4_q;
  logic [8:0]  s2_dist_q;

  assign el         = q_now_q - rd_word.stamp;
  assign s1_active  = v1_q && active_q[idx1_q];
  assign s1_expired = s1_active && (el > FADE_MS);
  assign s1_live    = s1_active && !(el > FADE_MS);
  assign el9        = el[8:0];
  assign dx         = (q_x_q >= rd_word.x) ? (q_x_q - rd_word.x) : (rd_word.x - q_x_q);
  assign dy         = (q_y_q >= rd_word.y) ? (q_y_q - rd_word.y) : (rd_word.y - q_y_q);

  always_ff @(posedge clk_i) begin
    s2_live_q    <= s1_live;
    s2_special_q <= rd_word.special;
    s2_match_q   <= (rd_word.led == q_led_q);
    s2_el51_q    <= 15'(el9) * 15'd51;
    s2_el4_q     <= {el9, 2'b00};
    s2_dist_q    <= 9'(dx) + 9'(dy);
  end

  // Stage 2: fade level and wave front radius.
  logic [30:0] fade_prod;
  logic [22:0] front_prod;
  logic        s3_live_q, s3_special_q, s3_match_q;
  logic [7:0]  s3_fade_q;
  logic [6:0]  s3_front_q;
  logic [8:0]  s3_dist_q;

  assign fade_prod  = 31'(s2_el51_q) * 31'(RECIP_100);
  assign front_prod = 23'(s2_el4_q) * 23'(RECIP_25);

  always_ff @(posedge clk_i) begin
    s3_live_q    <= s2_live_q;
    s3_special_q <= s2_special_q;
    s3_match_q   <= s2_match_q;
    s3_fade_q    <= 8'd255 - fade_prod[SHIFT_100 +: 8];
    s3_front_q   <= front_prod[SHIFT_25 +: 7];
    s3_dist_q    <= s2_dist_q;
  end

  // Stage 3: distance from the front and weighted fade.
  logic [8:0]  front9, dfront;
  logic        near;
  logic [3:0]  wgt;
  logic        s4_live_q, s4_special_q, s4_match_q, s4_near_q;
  logic [7:0]  s4_fade_q;
  logic [11:0] s4_prod_q;

  assign front9 = 9'(s3_front_q);
  assign dfront = (s3_dist_q >= front9) ? (s3_dist_q - front9) : (front9 - s3_dist_q);
  assign near   = dfront < RING_HALF_W;
  assign wgt    = near ? (4'(RING_HALF_W) - dfront[3:0]) : 4'd0;

  always_ff @(posedge clk_i) begin
    s4_live_q    <= s3_live_q;
    s4_special_q <= s3_special_q;
    s4_match_q   <= s3_match_q;
    s4_near_q    <= near;
    s4_fade_q    <= s3_fade_q;
    s4_prod_q    <= 12'(s3_fade_q) * 12'(wgt);
  end

  // Stage 4: ring brightness and compositing in slot order.
  logic [24:0] lb_prod;
  logic [7:0]  lb;
  out_word_t   colour_q, colour_d;
  out_word_t   preset;

  assign lb_prod = 25'(s4_prod_q) * 25'(RECIP_14);
  assign lb      = lb_prod[SHIFT_14 +: 8];
  assign preset  = preset_colour(base_idx_q);

  always_comb begin
    colour_d = colour_q;
    if (cmd_i.init_colour) begin
      colour_d.red   = div255(16'(preset.red) * 16'(bright_q));
      colour_d.green = div255(16'(preset.green) * 16'(bright_q));
      colour_d.blue  = div255(16'(preset.blue) * 16'(bright_q));
    end else if (v4_q && s4_live_q) begin
      if (s4_special_q) begin
        if (s4_near_q && (lb != 8'd0)) begin
          colour_d = '{red: lb, green: 8'd0, blue: 8'd0};
        end
      end else if (s4_match_q) begin
        colour_d = '{red: 8'd0, green: s4_fade_q, blue: 8'd0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    colour_q <= colour_d;
  end

  // Control registers.
  always_comb begin
    next_slot_d = next_slot_q;
    active_d    = active_q;
    walk_d      = walk_q;
    if (rec_we) begin
      active_d[next_slot_q] = 1'b1;
      next_slot_d = (next_slot_q == LastSlot) ? '0 : next_slot_q + 1'b1;
    end
    if (s1_expired) begin
      active_d[idx1_q] = 1'b0;
    end
    if (cmd_i.load_query) begin
      walk_d = '0;
    end else if (cmd_i.issue) begin
      walk_d = (walk_q == LastSlot) ? '0 : walk_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_slot_q <= '0;
      active_q    <= '0;
      walk_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      idx1_q      <= '0;
    end else begin
      next_slot_q <= next_slot_d;
      active_q    <= active_d;
      walk_q      <= walk_d;
      v1_q        <= cmd_i.issue;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      idx1_q      <= walk_q;
    end
  end

  assign status_o.walk_last  = (walk_q == LastSlot);
  assign status_o.pipe_empty = !(v1_q || v2_q || v3_q || v4_q);
  assign colour_o            = colour_q;

endmodule

>>> hw/rtl/reactive_key_led_compositor.sv
// A record word is taken and busy stays low.
// A query word holds busy through the base, walk, drain and result states; its colour
// appears on result_o with result_strobe_o for the last of them, so a new query is taken
// only once the last is done; the walk goes over the slot memory at one read a cycle.
// The receiver cannot stall; configuration writes are always taken.
// Reset clears every slot to inactive and the write pointer, and selects preset 0 at full brightness.
`timescale 1ns / 1ps

module reactive_key_led_compositor #(
  parameter int unsigned EVENT_SLOTS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  rklc_pkg::in_word_t             in_i,
  output rklc_pkg::out_word_t            result_o,
  output logic                           result_strobe_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rklc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                     cfg_data_i
);

  import rklc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  rklc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .op_i            (in_i.op),
    .status_i        (status),
    .cmd_o           (cmd),
    .busy            (busy),
    .result_strobe_o (result_strobe_o)
  );

  rklc_datapath #(
    .EVENT_SLOTS (EVENT_SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .colour_o    (result_o)
  );

endmodule

>>> test/reactive_key_led_compositor_tb.sv
`timescale 1ns / 1ps

module reactive_key_led_compositor_tb;
  import rklc_pkg::*;

  localparam int unsigned SLOT_COUNT    = 16;
  localparam int unsigned FADE_SPAN     = 500;
  localparam int unsigned WAVE_REACH    = 80;
  localparam int unsigned WAVE_HALF     = 14;
  localparam int unsigned FULL_SCALE    = 255;
  localparam int unsigned SETTLE_CYCLES = SLOT_COUNT + 15;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_WORDS   = 50;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  // Presets as {red, green, blue}; index 9 is black.
  localparam logic [23:0] PRESET_RGB [10] = '{
    24'h0000FF, 24'hFFC800, 24'h9400D3, 24'hFF1493, 24'h00C8C8,
    24'hFF5000, 24'h32FF32, 24'hFFFFFF, 24'hFF0000, 24'h000000
  };

  typedef struct {
    logic [7:0]  led;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        special;
    logic [31:0] stamp;
    logic        active;
  } key_press_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  in_word_t             in_i;
  out_word_t            result_o;
  logic                 result_strobe_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [7:0]           cfg_data_i;

  // Predictor state.
  key_press_t  press_ring [SLOT_COUNT];
  int unsigned ring_wr;
  logic [3:0]  colour_sel;
  logic [7:0]  brightness;
  out_word_t   colour_q [$];

  int unsigned mismatch_count;
  int unsigned cycle_count;

  // Stimulus state.
  logic [31:0] now_cursor;
  logic [7:0]  recent_led [4];
  logic [7:0]  recent_x [4];
  logic [7:0]  recent_y [4];
  int          burst_left;
  bit          gaps_on;

  reactive_key_led_compositor #(
    .EVENT_SLOTS(SLOT_COUNT)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_o       (result_o),
    .result_strobe_o(result_strobe_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && result_strobe_o) begin
      if (colour_q.size() == 0) begin
        report_mismatch($sformatf("colour %h with none expected", result_o));
      end else begin
        want = colour_q.pop_front();
        if (result_o.red !== want.red)
          report_mismatch($sformatf("red %0d, expected %0d", result_o.red, want.red));
        if (result_o.green !== want.green)
          report_mismatch($sformatf("green %0d, expected %0d", result_o.green, want.green));
        if (result_o.blue !== want.blue)
          report_mismatch($sformatf("blue %0d, expected %0d", result_o.blue, want.blue));
      end
    end
  end

  function automatic int unsigned span(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void record_press(input in_word_t w);
    if (w.led_index != NO_LED) begin
      press_ring[ring_wr] = '{led: w.led_index, x: w.led_x, y: w.led_y,
                              special: w.wave_key, stamp: w.now_ms, active: 1'b1};
      ring_wr = (ring_wr + 1) % SLOT_COUNT;
    end
  endfunction

  // Colour of one LED; expired presses are retired as a side effect.
  function automatic out_word_t render_colour(input in_word_t w);
    int unsigned r, g, b, elapsed, fade, front, manhattan, d, lit;
    logic [31:0] diff;
    logic [23:0] rgb;
    out_word_t   c;
    r = 0;
    g = 0;
    b = 0;
    if (colour_sel < PRESET_COUNT) begin
      rgb = PRESET_RGB[colour_sel];
      r = rgb[23:16];
      g = rgb[15:8];
      b = rgb[7:0];
      r = r * brightness / FULL_SCALE;
      g = g * brightness / FULL_SCALE;
      b = b * brightness / FULL_SCALE;
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!press_ring[i].active) continue;
      diff = w.now_ms - press_ring[i].stamp;
      elapsed = diff;
      if (elapsed > FADE_SPAN) begin
        press_ring[i].active = 1'b0;
        continue;
      end
      fade = FULL_SCALE - (elapsed * FULL_SCALE) / FADE_SPAN;
      if (press_ring[i].special) begin
        front = (elapsed * WAVE_REACH) / FADE_SPAN;
        manhattan = span(w.led_x, press_ring[i].x) + span(w.led_y, press_ring[i].y);
        if (manhattan <= front + WAVE_HALF && manhattan + WAVE_HALF >= front) begin
          d = span(front, manhattan);
          lit = (d < WAVE_HALF) ? fade * (WAVE_HALF - d) / WAVE_HALF : 0;
          if (lit > 0) begin
            r = lit;
            g = 0;
            b = 0;
          end
        end
      end else if (press_ring[i].led == w.led_index) begin
        r = 0;
        g = fade;
        b = 0;
      end
    end
    c.red = r[7:0];
    c.green = g[7:0];
    c.blue = b[7:0];
    return c;
  endfunction

  function automatic in_word_t make_word(input logic op, input logic [7:0] led,
                                         input logic [7:0] x, input logic [7:0] y,
                                         input logic special, input logic [31:0] now);
    in_word_t w;
    w.op = op;
    w.led_index = led;
    w.led_x = x;
    w.led_y = y;
    w.wave_key = special;
    w.now_ms = now;
    return w;
  endfunction

  function automatic logic [7:0] nudge(input logic [7:0] v, input int off);
    int s;
    s = int'(v) + off;
    if (s < 0) s = 0;
    if (s > 255) s = 255;
    return s[7:0];
  endfunction

  // Holds start until the word is taken, then updates the prediction.
  // start is left high so that a following word goes out on the next edge.
  task automatic send_word(input in_word_t w);
    if (!start) start <= 1'b1;
    in_i <= w;
    do @(posedge clk_i); while (busy);
    if (w.op == OP_QUERY) colour_q.push_back(render_colour(w));
    else record_press(w);
  endtask

  task automatic take_gap();
    int n;
    n = $urandom_range(1, 30);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
    burst_left = $urandom_range(1, 20);
  endtask

  task automatic put_word(input in_word_t w);
    send_word(w);
    burst_left--;
    if (gaps_on && burst_left <= 0) take_gap();
  endtask

  // Lets every outstanding query finish; records give no result, hence the pause.
  task automatic drain_results();
    if (start) start <= 1'b0;
    while (colour_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    if (!cfg_valid_i) cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_BASE_COLOUR) colour_sel = data[3:0];
    else if (idx == CFG_BRIGHTNESS) brightness = data;
  endtask

  task automatic set_config(input logic [3:0] sel, input logic [7:0] level,
                            input bit touch_unused);
    drain_results();
    if (touch_unused) write_reg(CFG_NO_REG, 8'($urandom()));
    write_reg(CFG_BASE_COLOUR, {4'($urandom()), sel});
    write_reg(CFG_BRIGHTNESS, level);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_state();
    put_word(make_word(OP_QUERY, 8'd0, 8'd0, 8'd0, 1'b0, 32'd0));
    put_word(make_word(OP_QUERY, 8'd254, 8'd255, 8'd255, 1'b1, 32'hFFFF_FFFF));
  endtask

  task automatic test_key_fade();
    put_word(make_word(OP_RECORD, 8'd7, 8'd40, 8'd20, 1'b0, 32'd1000));
    put_word(make_word(OP_QUERY, 8'd7, 8'd40, 8'd20, 1'b0, 32'd1000));
    put_word(make_word(OP_QUERY, 8'd7, 8'd40, 8'd20, 1'b0, 32'd1250));
    put_word(make_word(OP_QUERY, 8'd8, 8'd52, 8'd20, 1'b0, 32'd1250));
    // Fully faded but not yet expired: the LED goes black.
    put_word(make_word(OP_QUERY, 8'd7, 8'd40, 8'd20, 1'b0, 32'd1500));
    put_word(make_word(OP_QUERY, 8'd7, 8'd40, 8'd20, 1'b0, 32'd1501));
    // A step back in time looks like a huge age and clears the press.
    put_word(make_word(OP_RECORD, 8'd7, 8'd40, 8'd20, 1'b0, 32'd2000));
    put_word(make_word(OP_QUERY, 8'd7, 8'd40, 8'd20, 1'b0, 32'd1999));
    put_word(make_word(OP_RECORD, NO_LED, 8'd40, 8'd20, 1'b0, 32'd2100));
    put_word(make_word(OP_QUERY, 8'd7, 8'd40, 8'd20, 1'b0, 32'd2100));
  endtask

  task automatic test_wave();
    put_word(make_word(OP_RECORD, 8'd3, 8'd100, 8'd100, 1'b1, 32'd5000));
    put_word(make_word(OP_QUERY, 8'd3, 8'd100, 8'd100, 1'b0, 32'd5000));
    put_word(make_word(OP_QUERY, 8'd9, 8'd130, 8'd110, 1'b0, 32'd5250));
    put_word(make_word(OP_QUERY, 8'd9, 8'd153, 8'd100, 1'b0, 32'd5250));
    put_word(make_word(OP_QUERY, 8'd9, 8'd154, 8'd100, 1'b0, 32'd5250));
    put_word(make_word(OP_QUERY, 8'd3, 8'd100, 8'd100, 1'b0, 32'd5250));
    put_word(make_word(OP_QUERY, 8'd9, 8'd180, 8'd100, 1'b0, 32'd5500));
    // The press time sits just below the wrap of the millisecond counter.
    put_word(make_word(OP_RECORD, 8'd4, 8'd0, 8'd0, 1'b1, 32'hFFFF_FF00));
    put_word(make_word(OP_QUERY, 8'd4, 8'd0, 8'd43, 1'b0, 32'h0000_0010));
  endtask

  task automatic test_config_extremes();
    set_config(4'd0, 8'd0, 1'b0);
    put_word(make_word(OP_QUERY, 8'd1, 8'd2, 8'd3, 1'b0, 32'd9000));
    set_config(4'd9, 8'd255, 1'b0);
    put_word(make_word(OP_QUERY, 8'd1, 8'd2, 8'd3, 1'b0, 32'd9001));
    set_config(4'd15, 8'd128, 1'b1);
    put_word(make_word(OP_QUERY, 8'd1, 8'd2, 8'd3, 1'b0, 32'd9002));
  endtask

  // One burst of related traffic: presses, then queries aimed at them; now and then a single random word instead.
  task automatic run_scenario(ref int unsigned sent);
    int unsigned presses, queries, reach, j;
    int          dx, dy;
    logic [31:0] t;
    logic [7:0]  led;
    logic        op;
    if ($urandom_range(0, 9) == 0) begin
      op = 1'($urandom_range(0, 1));
      led = (op == OP_QUERY) ? 8'($urandom_range(0, 254)) : 8'($urandom_range(0, 255));
      t = $urandom_range(0, 1) ? $urandom() : now_cursor + $urandom_range(0, 1000);
      put_word(make_word(op, led, 8'($urandom()), 8'($urandom()), 1'($urandom()), t));
      sent++;
      return;
    end
    if ($urandom_range(0, 19) == 0) now_cursor = now_cursor - $urandom_range(1, 1000);
    t = now_cursor;
    presses = ($urandom_range(0, 9) == 0) ? 18 : $urandom_range(1, 4);
    for (int k = 0; k < presses; k++) begin
      j = k % 4;
      recent_led[j] = ($urandom_range(0, 15) == 0) ? NO_LED : 8'($urandom_range(0, 254));
      recent_x[j] = 8'($urandom_range(16, 239));
      recent_y[j] = 8'($urandom_range(16, 239));
      put_word(make_word(OP_RECORD, recent_led[j], recent_x[j], recent_y[j],
                         $urandom_range(0, 2) == 0, t));
      sent++;
      t = t + ((presses > 4) ? $urandom_range(0, 3) : $urandom_range(0, 30));
    end
    queries = $urandom_range(2, 8);
    for (int k = 0; k < queries; k++) begin
      t = t + $urandom_range(0, 80);
      j = $urandom_range(0, 3);
      led = ($urandom_range(0, 2) != 0 && recent_led[j] != NO_LED) ?
            recent_led[j] : 8'($urandom_range(0, 254));
      reach = $urandom_range(0, 100);
      dx = $urandom_range(0, reach);
      dy = reach - dx;
      if ($urandom_range(0, 1)) dx = -dx;
      if ($urandom_range(0, 1)) dy = -dy;
      put_word(make_word(OP_QUERY, led, nudge(recent_x[j], dx), nudge(recent_y[j], dy),
                         1'($urandom()), t));
      sent++;
    end
    now_cursor = t + $urandom_range(0, 200);
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    logic [3:0]  sel;
    logic [7:0]  level;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      sel = (p == 0) ? 4'd7 : 4'($urandom_range(0, 15));
      level = (p == 1) ? 8'd0 : (p == 2) ? 8'd255 : 8'($urandom());
      set_config(sel, level, p == 4);
      gaps_on = ($urandom_range(0, 3) != 0);
      if (p == 3) now_cursor = 32'hFFFF_FE00;
      sent = 0;
      while (sent < PHASE_WORDS) run_scenario(sent);
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    start <= 1'b0;
    in_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    cycle_count = 0;
    mismatch_count = 0;
    foreach (press_ring[i]) press_ring[i].active = 1'b0;
    ring_wr = 0;
    colour_sel = BASE_COLOUR_RESET;
    brightness = BRIGHTNESS_RESET;
    now_cursor = $urandom();
    foreach (recent_led[i]) begin
      recent_led[i] = 8'd0;
      recent_x[i] = 8'd0;
      recent_y[i] = 8'd0;
    end
    gaps_on = 1'b1;
    burst_left = $urandom_range(1, 20);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_key_fade();
    test_wave();
    test_config_extremes();
    test_random_traffic();

    drain_results();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
